// File: rtl/core/vbrsel_pkg.sv
// Shared constants, register codes and the rate table of the bitrate selector.
`timescale 1ns / 1ps

package vbrsel_pkg;

  // Field widths
  localparam int CPLX_W   = 17;
  localparam int BYTES_W  = 12;
  localparam int KBPS_W   = 9;
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int BITS_W   = 48;
  localparam int FRAMES_W = 32;
  localparam int TGT_W    = 13;

  // Rate modes
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ABR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KBPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KBPS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KBPS = 2'd3;

  // Register values after reset
  localparam logic [KBPS_W-1:0] MIN_KBPS_RST = 9'd32;
  localparam logic [KBPS_W-1:0] MAX_KBPS_RST = 9'd320;

  localparam logic [CPLX_W-1:0] Q16_ONE = 17'h10000;
  localparam logic [TGT_W-1:0]  QUOT_CAP = 13'd4096;

  // Index codes
  localparam logic [IDX_W-1:0] IDX_OFF = 4'd9;
  localparam logic [IDX_W-1:0] IDX_TOP = 4'd14;

  typedef logic [KBPS_W-1:0] kbps_t;

  // Layer III rates, kbps, by index
  localparam kbps_t LEGAL_KBPS [15] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320
  };

  // Lowest legal rate in [lo, hi] at or above the target; failing that the
  // highest legal rate in range; failing that the top index.
  function automatic logic [IDX_W-1:0] pick_index(
    input logic [TGT_W-1:0]  tgt,
    input logic [KBPS_W-1:0] lo,
    input logic [KBPS_W-1:0] hi
  );
    logic [IDX_W-1:0] idx;
    logic             found;
    logic             in_rng;
    kbps_t            r;
    idx   = IDX_TOP;
    found = 1'b0;
    for (int i = 1; i < 15; i++) begin
      r      = LEGAL_KBPS[i];
      in_rng = (r >= lo) && (r <= hi);
      if (!found && in_rng && ({4'b0, r} >= tgt)) begin
        idx   = IDX_W'(i);
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 1; i < 15; i++) begin
        r = LEGAL_KBPS[i];
        if ((r >= lo) && (r <= hi)) begin
          idx = IDX_W'(i);
        end
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/vbrsel_if.sv
// Handshake interfaces of the bitrate selector: request, response, configuration.
`timescale 1ns / 1ps

interface vbrsel_req_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [vbrsel_pkg::CPLX_W-1:0]   complexity_q16;
  logic [vbrsel_pkg::BYTES_W-1:0]  frame_size_bytes;
  modport source (output valid, action, complexity_q16, frame_size_bytes, input ready);
  modport sink   (input valid, action, complexity_q16, frame_size_bytes, output ready);
endinterface

interface vbrsel_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vbrsel_pkg::IDX_W-1:0]  rate_index;
  modport source (output valid, rate_index, input ready);
  modport sink   (input valid, rate_index, output ready);
endinterface

interface vbrsel_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vbrsel_pkg::CFG_IDX_W-1:0]  index;
  logic [vbrsel_pkg::KBPS_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/vbr_abr_bitrate_selector.sv
// Per-frame bitrate selector: top level with sequencer and shared multiplier.
//
// Chooses a Layer III bitrate index for the next frame from a Q16 complexity
// (clamped to 1.0) in variable (linear min..max mapping) or average bitrate
// mode, and returns index 9 when the mode is off. A record request adds the
// frame's bits and one frame to saturating running totals and gives no
// response; req.ready is high again the next cycle. A select request holds
// req.ready low until its result is in the response register: with the mode
// off it goes straight to the index pick; variable mode, and average mode
// while the target or a total is zero, make one pass through the one 26x32
// multiplier; average mode otherwise makes four passes, one wide add and a
// 13-step restoring divider whose quotient saturates at 4096 (the divider
// stops after its first step when it does). The response register holds a
// finished result while the next request is taken. Configuration writes are
// taken in any cycle and must only be issued while the block is idle.
`timescale 1ns / 1ps

module vbr_abr_bitrate_selector (
  input  logic       clk,
  input  logic       rst,
  vbrsel_req_if.sink   req,
  vbrsel_rsp_if.source rsp,
  vbrsel_cfg_if.sink   cfg
);
  import vbrsel_pkg::*;

  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int REM_W   = 75;
  localparam int CNT_W   = 4;
  localparam logic [CNT_W-1:0] DIV_TOP = 4'd12;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MUL_TC  = 9'b000000010,
    ST_MUL_T5  = 9'b000000100,
    ST_MUL_FLO = 9'b000001000,
    ST_MUL_FHI = 9'b000010000,
    ST_ADD     = 9'b000100000,
    ST_DIV     = 9'b001000000,
    ST_CLAMP   = 9'b010000000,
    ST_PICK    = 9'b100000000
  } state_t;

  // Configuration registers
  logic [MODE_W-1:0]   rate_mode;
  logic [KBPS_W-1:0]   min_rate_kbps;
  logic [KBPS_W-1:0]   max_rate_kbps;
  logic [KBPS_W-1:0]   average_target_kbps;

  // Running totals
  logic [BITS_W-1:0]   bits_accumulated;
  logic [FRAMES_W-1:0] frames_accumulated;

  // Sequencer and datapath
  state_t              state;
  state_t              state_next;
  logic [CPLX_W-1:0]   c_r;
  logic [MUL_P_W-1:0]  prod_r;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    div_d;
  logic [11:0]         quot;
  logic [CNT_W-1:0]    cnt;
  logic [TGT_W-1:0]    t_r;
  logic                rsp_valid;
  logic [IDX_W-1:0]    rsp_index;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic                mode_off;
  logic                mode_vbr;
  logic                avg_fast;
  logic                span_neg;
  logic [KBPS_W-1:0]   span_abs;
  logic [11:0]         t5;
  logic [REM_W-1:0]    d_init;
  logic                div_ge;
  logic [TGT_W-1:0]    t_vbr;
  logic [TGT_W-1:0]    t_avg;
  logic [TGT_W-1:0]    t_lo;
  logic [TGT_W-1:0]    t_clamped;
  logic                req_fire;
  logic                pick_fire;
  logic [BITS_W:0]     bits_sum;

  assign mode_off = (rate_mode == MODE_OFF);
  assign mode_vbr = (rate_mode == MODE_VBR);
  // Undefined mode code behaves as average mode: anything not off or VBR.
  assign avg_fast = (average_target_kbps == '0) || (bits_accumulated == '0) ||
                    (frames_accumulated == '0);

  assign span_neg = (max_rate_kbps < min_rate_kbps);
  assign span_abs = span_neg ? (min_rate_kbps - max_rate_kbps)
                             : (max_rate_kbps - min_rate_kbps);
  // Target times five, fed to the second multiply
  assign t5 = {1'b0, average_target_kbps, 2'b00} + {3'b000, average_target_kbps};

  // Divisor B*12544 pre-shifted by the 12 quotient bits: 12544 = 49 << 8
  assign d_init = REM_W'({bits_accumulated, 25'b0}) + REM_W'({bits_accumulated, 24'b0}) +
                  REM_W'({bits_accumulated, 20'b0});

  // Shared multiplier: operand selection by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_TC: begin
        mul_a = MUL_A_W'(c_r);
        mul_b = mode_vbr ? MUL_B_W'(span_abs) : MUL_B_W'(average_target_kbps);
      end
      ST_MUL_T5: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(t5);
      end
      ST_MUL_FLO: begin
        mul_a = MUL_A_W'(prod_r[15:0]);
        mul_b = frames_accumulated;
      end
      ST_MUL_FHI: begin
        mul_a = MUL_A_W'(prod_r[37:16]);
        mul_b = frames_accumulated;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  assign div_ge = (rem >= div_d);

  // Target formation and clamp to [min, max] for average mode
  assign t_vbr = span_neg ? (TGT_W'(min_rate_kbps) - TGT_W'(prod_r[25:16]))
                          : (TGT_W'(min_rate_kbps) + TGT_W'(prod_r[25:16]));
  assign t_avg = avg_fast ? TGT_W'(prod_r[25:16]) : t_r;
  assign t_lo  = (t_avg < TGT_W'(min_rate_kbps)) ? TGT_W'(min_rate_kbps) : t_avg;
  assign t_clamped = (t_lo > TGT_W'(max_rate_kbps)) ? TGT_W'(max_rate_kbps) : t_lo;

  // Take nothing while reset is held
  assign req.ready = (state == ST_IDLE) && !rst;
  assign req_fire  = req.valid && req.ready;
  assign pick_fire = (state == ST_PICK) && (!rsp_valid || rsp.ready);

  assign rsp.valid      = rsp_valid;
  assign rsp.rate_index = rsp_index;
  assign cfg.ready      = !rst;

  assign bits_sum = {1'b0, bits_accumulated} + (BITS_W + 1)'({req.frame_size_bytes, 3'b000});

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && !req.action) begin
          state_next = mode_off ? ST_PICK : ST_MUL_TC;
        end
      end
      ST_MUL_TC:  state_next = (mode_vbr || avg_fast) ? ST_CLAMP : ST_MUL_T5;
      ST_MUL_T5:  state_next = ST_MUL_FLO;
      ST_MUL_FLO: state_next = ST_MUL_FHI;
      ST_MUL_FHI: state_next = ST_ADD;
      ST_ADD:     state_next = ST_DIV;
      ST_DIV: begin
        // Saturate on the first step, else run down to the last bit
        if ((cnt == DIV_TOP && div_ge) || cnt == '0) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP:   state_next = ST_PICK;
      ST_PICK: begin
        if (pick_fire) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mode           <= MODE_OFF;
      min_rate_kbps       <= MIN_KBPS_RST;
      max_rate_kbps       <= MAX_KBPS_RST;
      average_target_kbps <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_RATE_MODE:   rate_mode           <= cfg.data[MODE_W-1:0];
        CFG_MIN_KBPS:    min_rate_kbps       <= cfg.data;
        CFG_MAX_KBPS:    max_rate_kbps       <= cfg.data;
        CFG_TARGET_KBPS: average_target_kbps <= cfg.data;
        default: ;
      endcase
    end
  end

  // Running totals: both saturate at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_accumulated   <= '0;
      frames_accumulated <= '0;
    end else if (req_fire && req.action) begin
      bits_accumulated <= bits_sum[BITS_W] ? {BITS_W{1'b1}} : bits_sum[BITS_W-1:0];
      if (frames_accumulated != {FRAMES_W{1'b1}}) begin
        frames_accumulated <= frames_accumulated + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // Clamp complexity to 1.0 and preload the shifted divisor
        c_r   <= (req.complexity_q16 > Q16_ONE) ? Q16_ONE : req.complexity_q16;
        div_d <= d_init;
      end
      ST_MUL_TC, ST_MUL_T5, ST_MUL_FHI: begin
        prod_r <= mul_p;
      end
      ST_MUL_FLO: begin
        // Low partial product of the dividend; prod_r keeps the high half
        rem <= REM_W'(mul_p);
      end
      ST_ADD: begin
        rem <= rem + REM_W'({prod_r[53:0], 16'b0});
        cnt <= DIV_TOP;
      end
      ST_DIV: begin
        if (cnt == DIV_TOP && div_ge) begin
          t_r <= QUOT_CAP;
        end else begin
          if (div_ge) begin
            rem <= rem - div_d;
          end
          quot  <= {quot[10:0], div_ge};
          div_d <= div_d >> 1;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            t_r <= {1'b0, quot[10:0], div_ge};
          end
        end
      end
      ST_CLAMP: begin
        t_r <= mode_vbr ? t_vbr : t_clamped;
      end
      default: ;
    endcase
  end

  // Response register: hold a result until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pick_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_fire) begin
      rsp_index <= mode_off ? IDX_OFF : pick_index(t_r, min_rate_kbps, max_rate_kbps);
    end
  end

endmodule

// File: rtl/core/vbrsel_checker.sv
// Port-level assertions for the bitrate selector, bound to its top level.
`timescale 1ns / 1ps

module vbrsel_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        req_action,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [vbrsel_pkg::IDX_W-1:0] rsp_rate_index
);
  import vbrsel_pkg::*;

  // A stalled response keeps its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate_index))
    else $error("response changed while stalled");

  a_rsp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_rate_index != '0 && rsp_rate_index <= IDX_TOP)
    else $error("rate index outside 1..14");

  // A select transfer occupies the block for at least the next cycle
  a_select_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_action |=> !req_ready)
    else $error("select request did not make the block busy");

  // A record transfer leaves the block ready again in the next cycle
  a_record_quick: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_action |=> req_ready)
    else $error("record request held the block");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind vbr_abr_bitrate_selector vbrsel_checker u_vbrsel_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_action     (req.action),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_rate_index (rsp.rate_index)
);
